FILE: hdl/pfi_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the Pareto frontier insertion block.
// Used by pfi_cell and pareto_frontier_insert; depends on nothing.
package pfi_pkg;

    localparam int FRONTIER_DEPTH_DEF = 16;
    localparam int TIME_W             = 32;
    localparam int COST_W             = 32;
    localparam int STATUS_W           = 2;
    localparam int POS_OUT_W          = 4;
    localparam int CNT_OUT_W          = 5;

    typedef struct packed {
        logic [TIME_W-1:0] arr_time;
        logic [COST_W-1:0] cost;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_SHL  = 2'd1,
        OP_SHR  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   item;
    } cell_ctrl_t;

    typedef struct packed {
        logic lt;
        logic dom;
        logic prune;
        logic is_pos;
    } cell_flag_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_DOMINATED = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_CLEARED   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_PRUNE  = 5'b00100,
        S_PLACE  = 5'b01000,
        S_REPORT = 5'b10000
    } state_t;

endpackage

FILE: hdl/pfi_cell.sv
`timescale 1ns / 1ps
// One frontier cell: holds a label, compares it with the pending item and
// shifts toward either neighbor. Depends on pfi_pkg.
module pfi_cell
    import pfi_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count,
    input  entry_t           left_entry,
    input  logic             left_lt,
    input  entry_t           right_entry,
    output entry_t           entry,
    output cell_flag_t       flag
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid;
    logic   t_lt;
    logic   t_le;
    logic   c_le;
    logic   c_ge;

    assign valid = (count > CNT_W'(IDX));
    assign t_lt  = entry_reg.arr_time <  ctrl.item.arr_time;
    assign t_le  = entry_reg.arr_time <= ctrl.item.arr_time;
    assign c_le  = entry_reg.cost     <= ctrl.item.cost;
    assign c_ge  = entry_reg.cost     >= ctrl.item.cost;

    always_comb
    begin
        flag.lt     = valid & t_lt;
        flag.dom    = valid & t_le & c_le;
        flag.prune  = valid & ~t_lt & c_ge;
        flag.is_pos = ~(valid & t_lt) & left_lt;
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_HOLD:
            begin
                entry_next = entry_reg;
            end
            OP_SHL:
            begin
                if (!flag.lt)
                begin
                    entry_next = right_entry;
                end
            end
            OP_SHR:
            begin
                if (flag.is_pos)
                begin
                    entry_next = ctrl.item;
                end
                else if (!flag.lt)
                begin
                    entry_next = left_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: hdl/pareto_frontier_insert.sv
`timescale 1ns / 1ps
// Top level of the Pareto frontier insertion block: control sequencer,
// result register and the row of pfi_cell instances. Depends on pfi_pkg.
//
//  group  dir  tdata (low bit up)                         tuser
//  s_*    in   arr_time[31:0], cost[63:32]                mode
//  m_*    out  insert_position[3:0], pruned_count[8:4],   status
//              entry_count[13:9], zero[15:14]
//
// An item is taken in the idle state and evaluated; then each pruned label
// is removed by a left shift through the cell row (plus a final prune step
// that sees the run end), then the item is placed and the result reported.
// Clear and rejected items go from evaluation straight to the report step.
// Reset empties the frontier at once; label storage is not cleared.
// A stalled output holds the block in its report step; no item is taken.
module pareto_frontier_insert
    import pfi_pkg::*;
#(
    parameter int FRONTIER_DEPTH = FRONTIER_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // arr_time[31:0], cost[63:32]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // insert_position, pruned_count, entry_count
    output logic [1:0]  m_tuser    // status
);

    localparam int CNT_W = $clog2(FRONTIER_DEPTH + 1);
    localparam int IDX_W = $clog2(FRONTIER_DEPTH);

    state_t            state_reg, state_next;
    logic              mode_reg, mode_next;
    entry_t            item_reg, item_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pruned_reg, pruned_next;
    status_t           res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_pos_reg, res_pos_next;
    logic [CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    cell_ctrl_t        ctrl;
    entry_t            entries [FRONTIER_DEPTH];
    cell_flag_t        flags   [FRONTIER_DEPTH];
    logic [FRONTIER_DEPTH-1:0] dom_vec;
    logic [FRONTIER_DEPTH-1:0] prune_vec;
    logic              any_dom;
    logic              any_prune;
    logic [IDX_W-1:0]  pos;
    logic              s_fire;
    logic              out_free;
    logic [31:0]       pos_ext;
    logic [31:0]       pruned_ext;
    logic [31:0]       cnt_ext;

    genvar gi;
    generate
        for (gi = 0; gi < FRONTIER_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_l;

            if (gi == 0)
            begin : g_first
                assign left_e = ctrl.item;
                assign left_l = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = entries[gi-1];
                assign left_l = flags[gi-1].lt;
            end

            if (gi == FRONTIER_DEPTH - 1)
            begin : g_last
                assign right_e = ctrl.item;
            end
            else
            begin : g_inner
                assign right_e = entries[gi+1];
            end

            pfi_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .left_entry  (left_e),
                .left_lt     (left_l),
                .right_entry (right_e),
                .entry       (entries[gi]),
                .flag        (flags[gi])
            );

            assign dom_vec[gi]   = flags[gi].dom;
            assign prune_vec[gi] = flags[gi].prune;
        end
    endgenerate

    assign any_dom   = |dom_vec;
    assign any_prune = |prune_vec;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < FRONTIER_DEPTH; i++)
        begin
            if (flags[i].is_pos)
            begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb
    begin
        ctrl.item = item_reg;
        ctrl.op   = OP_HOLD;
        if ((state_reg == S_PRUNE) && any_prune)
        begin
            ctrl.op = OP_SHL;
        end
        else if (state_reg == S_PLACE)
        begin
            ctrl.op = OP_SHR;
        end
    end

    assign pos_ext    = 32'(res_pos_reg);
    assign pruned_ext = 32'(pruned_reg);
    assign cnt_ext    = 32'(res_cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        pruned_next     = pruned_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_cnt_next    = res_cnt_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    mode_next          = s_tuser;
                    item_next.arr_time = s_tdata[31:0];
                    item_next.cost     = s_tdata[63:32];
                    pruned_next        = '0;
                    state_next         = S_EVAL;
                end
            end
            S_EVAL:
            begin
                res_pos_next = '0;
                if (mode_reg)
                begin
                    count_next      = '0;
                    res_status_next = STAT_CLEARED;
                    res_cnt_next    = '0;
                    state_next      = S_REPORT;
                end
                else if (any_dom)
                begin
                    res_status_next = STAT_DOMINATED;
                    res_cnt_next    = count_reg;
                    state_next      = S_REPORT;
                end
                else if ((count_reg == CNT_W'(FRONTIER_DEPTH)) && !any_prune)
                begin
                    res_status_next = STAT_FULL;
                    res_cnt_next    = count_reg;
                    state_next      = S_REPORT;
                end
                else if (any_prune)
                begin
                    state_next = S_PRUNE;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PRUNE:
            begin
                if (any_prune)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    pruned_next = pruned_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                count_next      = count_reg + CNT_W'(1);
                res_status_next = STAT_INSERTED;
                res_pos_next    = pos;
                res_cnt_next    = count_reg + CNT_W'(1);
                state_next      = S_REPORT;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {2'b00,
                                     cnt_ext[CNT_OUT_W-1:0],
                                     (res_status_reg == STAT_INSERTED) ?
                                         pruned_ext[CNT_OUT_W-1:0] : 5'd0,
                                     pos_ext[POS_OUT_W-1:0]};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        item_reg       <= item_next;
        pruned_reg     <= pruned_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_cnt_reg    <= res_cnt_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FRONTIER_DEPTH))
        else $error("frontier count above depth");

    a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE) |-> (count_reg < CNT_W'(FRONTIER_DEPTH)))
        else $error("placement into a full frontier");

    a_prune_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PRUNE) && any_prune) |-> (count_reg != '0))
        else $error("prune step on an empty frontier");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_REPORT))
        else $error("result raised outside the report step");

endmodule
